[rtl/wrf_pkg.sv]
// Shared types and constants of the windowed angular rate fit.
package wrf_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_PROD  = 9'b000000100,
    S_MUL1  = 9'b000001000,
    S_MUL2  = 9'b000010000,
    S_SCALE = 9'b000100000,
    S_DIVGO = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  // Configuration register indexes.
  localparam logic [7:0] REG_WINDOW_LEN     = 8'd0;
  localparam logic [7:0] REG_JUMP_THRESHOLD = 8'd1;

  localparam logic [6:0]  WINDOW_LEN_RESET     = 7'd16;
  localparam logic [14:0] JUMP_THRESHOLD_RESET = 15'd4289;

  localparam logic [31:0] RATE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RATE_MIN = 32'h8000_0000;

endpackage

[rtl/windowed_angular_rate_fit.sv]
// Top level of the windowed angular rate fit: window store, sequencer and result register.
//
// Channel   Direction  Signals                                    Moves
// in        input      in_valid_i/in_ready_o, sample_angle_i,     one sample request
//                      sample_time_i
// out       output     out_valid_o/out_ready_i, rate_o,           one fit result
//                      rate_valid_o, window_count_o
// cfg       input      cfg_valid_i/cfg_ready_o, cfg_index_i,      one register write
//                      cfg_data_i
//
// A request first walks the window memory through the sum pipeline, then runs the serial
// multiply by |Sum(f)| and then by Sum(x), each stopping once its multiplier bits are used
// up (at most 22 and 38 bits), then the serial divide unless the denominator is zero, and
// the sequencing steps; a window of one goes straight to the result.
// The input is ready only in the idle state; the result is held until it is taken.
// Reset clears the window (fill and oldest slot), the last angle and the configuration registers.
// Configuration writes are always taken and apply to the next request.
module windowed_angular_rate_fit #(
  parameter int MAX_WINDOW = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_angle_i,
  input  logic [31:0]        sample_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rate_o,
  output logic               rate_valid_o,
  output logic [6:0]         window_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int LW   = CW + 7;
  localparam int SXW  = 32 + CW;
  localparam int SXXW = 64 + CW;
  localparam int SFW  = 16 + CW;
  localparam int SXFW = 48 + CW;
  localparam int PW   = 2 * SXW;
  localparam int NUMW = 49 + 2 * CW;
  localparam int DENW = 64 + 2 * CW;
  localparam int DVW  = 65 + 2 * CW;

  localparam logic [CW:0]   MW_W   = (CW + 1)'(MAX_WINDOW);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_WINDOW - 1);

  wrf_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [6:0]  win_len_q;
  logic [14:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= wrf_pkg::WINDOW_LEN_RESET;
      thr_q     <= wrf_pkg::JUMP_THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wrf_pkg::REG_WINDOW_LEN:     win_len_q <= cfg_data_i[6:0];
        wrf_pkg::REG_JUMP_THRESHOLD: thr_q     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Window bookkeeping for an incoming request.
  logic [CW-1:0]     fill_q, n_q, rd_cnt_q;
  logic [AW-1:0]     oldest_q, rd_addr_q;
  logic signed [15:0] last_q;

  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic               jump;
  logic [LW-1:0]      len_w;
  logic [CW-1:0]      len_c, fill_eff, drop, fill_new;
  logic [AW-1:0]      oldest_eff, oldest_new, slot;
  logic [CW:0]        osum, ssum;
  logic               accept_in;

  assign accept_in = in_valid_i && in_ready_o;

  always_comb begin
    diff     = {sample_angle_i[15], sample_angle_i} - {last_q[15], last_q};
    diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
    jump     = diff_mag > {2'b00, thr_q};

    // The window length is clamped to one through the store depth.
    len_w = LW'(win_len_q);
    if (len_w == '0) begin
      len_w = LW'(1);
    end else if (len_w > LW'(MAX_WINDOW)) begin
      len_w = LW'(MAX_WINDOW);
    end
    len_c = len_w[CW-1:0];

    fill_eff   = jump ? '0 : fill_q;
    oldest_eff = jump ? '0 : oldest_q;

    // A full window drops just enough of its oldest entries to make room.
    drop = fill_eff - len_c + 1'b1;
    osum = (CW + 1)'(oldest_eff) + (CW + 1)'(drop);
    if (osum >= MW_W) begin
      osum = osum - MW_W;
    end
    if (fill_eff >= len_c) begin
      oldest_new = osum[AW-1:0];
      fill_new   = len_c - 1'b1;
    end else begin
      oldest_new = oldest_eff;
      fill_new   = fill_eff;
    end

    ssum = (CW + 1)'(oldest_new) + (CW + 1)'(fill_new);
    if (ssum >= MW_W) begin
      ssum = ssum - MW_W;
    end
    slot = ssum[AW-1:0];
  end

  // Window store: angle in the upper bits, time in the lower bits.
  logic [47:0] mem [MAX_WINDOW];
  logic [47:0] rdata_q;
  logic        rd_en, rd_v_q, rd_first_q;

  assign rd_en = (state_q == wrf_pkg::S_READ) && (rd_cnt_q != n_q);

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      mem[slot] <= {sample_angle_i, sample_time_i};
    end
    rdata_q <= mem[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q     <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_v_q     <= rd_en;
      rd_first_q <= rd_en && (rd_cnt_q == '0);
    end
  end

  // Sums over the window.
  logic [SXW-1:0]         sx;
  logic [SXXW-1:0]        sxx;
  logic signed [SFW-1:0]  sf;
  logic signed [SXFW-1:0] sxf;
  logic                   acc_busy;

  wrf_acc #(.CW(CW)) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept_in),
    .valid_i (rd_v_q),
    .first_i (rd_first_q),
    .time_i  (rdata_q[31:0]),
    .angle_i (rdata_q[47:32]),
    .busy_o  (acc_busy),
    .sx_o    (sx),
    .sxx_o   (sxx),
    .sf_o    (sf),
    .sxf_o   (sxf)
  );

  // Shared serial multiplier: first Sum(x)*|Sum(f)|, then Sum(x)^2.
  logic            mul_start, mul_done;
  logic [SXW-1:0]  mul_b;
  logic [PW-1:0]   mul_p;

  wrf_mul #(.W(SXW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (sx),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // Serial divider for the rounded quotient.
  logic            div_start, div_done;
  logic [DVW-1:0]  div_q;
  logic [DVW-1:0]  scaled_q;
  logic [DENW-1:0] den1_q, den_q;

  wrf_div #(.NW(DVW), .DW(DENW + 1)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scaled_q + DVW'(den_q)),
    .divisor_i  ({den_q, 1'b0}),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // Numerator and scaling arithmetic.
  logic                   sxf_neg, sf_neg_q, sxf_neg_q, num_neg_q;
  logic [SXFW-1:0]        sxf_mag;
  logic [SFW-1:0]         sf_mag;
  logic [SXFW+CW-1:0]     a_q;
  logic signed [NUMW-1:0] num_a, num_b, num_q, num_mag;
  logic [31:0]            rate_sat;
  logic                   q_hi;

  always_comb begin
    sxf_neg = sxf[SXFW-1];
    sxf_mag = sxf_neg ? SXFW'(-sxf) : SXFW'(sxf);
    sf_mag  = sf[SFW-1] ? SFW'(-sf) : SFW'(sf);
    mul_b   = (state_q == wrf_pkg::S_PROD) ? SXW'(sf_mag) : sx;

    num_a = NUMW'(a_q);
    num_b = NUMW'(mul_p);
    if (sxf_neg_q) begin
      num_a = -num_a;
    end
    if (sf_neg_q) begin
      num_b = -num_b;
    end

    num_mag = num_q[NUMW-1] ? -num_q : num_q;

    // Round to nearest with ties away from zero, then saturate to the signed range.
    q_hi = |div_q[DVW-1:32];
    if (num_neg_q) begin
      rate_sat = (q_hi || (div_q[31:0] > wrf_pkg::RATE_MIN)) ? wrf_pkg::RATE_MIN
                                                             : -div_q[31:0];
    end else begin
      rate_sat = (q_hi || div_q[31]) ? wrf_pkg::RATE_MAX : div_q[31:0];
    end
  end

  assign mul_start = (state_q == wrf_pkg::S_PROD) ||
                     ((state_q == wrf_pkg::S_MUL1) && mul_done);
  assign div_start = (state_q == wrf_pkg::S_DIVGO);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wrf_pkg::S_IDLE: begin
        if (accept_in) begin
          state_d = (fill_new == '0) ? wrf_pkg::S_OUT : wrf_pkg::S_READ;
        end
      end
      wrf_pkg::S_READ: begin
        if ((rd_cnt_q == n_q) && !rd_v_q && !acc_busy) begin
          state_d = wrf_pkg::S_PROD;
        end
      end
      wrf_pkg::S_PROD:  state_d = wrf_pkg::S_MUL1;
      wrf_pkg::S_MUL1:  if (mul_done) state_d = wrf_pkg::S_MUL2;
      wrf_pkg::S_MUL2:  if (mul_done) state_d = wrf_pkg::S_SCALE;
      wrf_pkg::S_SCALE: state_d = (den_q == '0) ? wrf_pkg::S_OUT : wrf_pkg::S_DIVGO;
      wrf_pkg::S_DIVGO: state_d = wrf_pkg::S_DIV;
      wrf_pkg::S_DIV:   if (div_done) state_d = wrf_pkg::S_OUT;
      wrf_pkg::S_OUT:   if (out_ready_i) state_d = wrf_pkg::S_IDLE;
      default:          state_d = wrf_pkg::S_IDLE;
    endcase
  end

  logic signed [31:0] rate_q;
  logic               rate_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wrf_pkg::S_IDLE;
      fill_q       <= '0;
      oldest_q     <= '0;
      last_q       <= '0;
      n_q          <= '0;
      rd_cnt_q     <= '0;
      rd_addr_q    <= '0;
      rate_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept_in) begin
        fill_q       <= fill_new + 1'b1;
        oldest_q     <= oldest_new;
        last_q       <= sample_angle_i;
        n_q          <= fill_new + 1'b1;
        rd_cnt_q     <= '0;
        rd_addr_q    <= oldest_new;
        rate_valid_q <= 1'b0;
      end
      if (rd_en) begin
        rd_cnt_q  <= rd_cnt_q + 1'b1;
        rd_addr_q <= (rd_addr_q == LAST_A) ? '0 : rd_addr_q + 1'b1;
      end
      if ((state_q == wrf_pkg::S_DIV) && div_done) begin
        rate_valid_q <= 1'b1;
      end
    end
  end

  // Result payload; a short or degenerate window reports a zero rate.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      rate_q <= '0;
    end
    if (state_q == wrf_pkg::S_PROD) begin
      a_q       <= (SXFW + CW)'(sxf_mag * n_q);
      den1_q    <= DENW'(sxx * n_q);
      sxf_neg_q <= sxf_neg;
      sf_neg_q  <= sf[SFW-1];
    end
    if ((state_q == wrf_pkg::S_MUL1) && mul_done) begin
      num_q <= num_a - num_b;
    end
    if ((state_q == wrf_pkg::S_MUL2) && mul_done) begin
      den_q <= den1_q - DENW'(mul_p);
    end
    if (state_q == wrf_pkg::S_SCALE) begin
      // Scale by 16000: ms to s, Q3.13 to Q16.16, and doubled for rounding.
      num_neg_q <= num_q[NUMW-1];
      scaled_q  <= (DVW'(num_mag) << 14) - (DVW'(num_mag) << 8) - (DVW'(num_mag) << 7);
    end
    if ((state_q == wrf_pkg::S_DIV) && div_done) begin
      rate_q <= rate_sat;
    end
  end

  assign in_ready_o     = (state_q == wrf_pkg::S_IDLE);
  assign out_valid_o    = (state_q == wrf_pkg::S_OUT);
  assign rate_o         = rate_q;
  assign rate_valid_o   = rate_valid_q;
  assign window_count_o = 7'(n_q);

  // The block never takes a request while it holds a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // A valid rate needs at least two samples in the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rate_valid_o) |-> (window_count_o != 7'd0 && window_count_o != 7'd1))
    else $error("valid rate with fewer than two samples");

  // Every result reports a nonempty window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_count_o != 7'd0))
    else $error("result with an empty window");

  // An accepted request makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a request");

endmodule

[rtl/wrf_acc.sv]
// Pipelined sum unit: time offsets, products and the four running sums of the fit.
module wrf_acc #(
  parameter int CW = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    valid_i,
  input  logic                    first_i,
  input  logic [31:0]             time_i,
  input  logic signed [15:0]      angle_i,
  output logic                    busy_o,
  output logic [32+CW-1:0]        sx_o,
  output logic [64+CW-1:0]        sxx_o,
  output logic signed [16+CW-1:0] sf_o,
  output logic signed [48+CW-1:0] sxf_o
);

  logic               v1_q, v2_q;
  logic [31:0]        t0_q, x1_q, x2_q;
  logic signed [15:0] f1_q, f2_q;
  logic [63:0]        pxx_q;
  logic signed [48:0] pxf_q;
  logic [32+CW-1:0]        sx_q;
  logic [64+CW-1:0]        sxx_q;
  logic signed [16+CW-1:0] sf_q;
  logic signed [48+CW-1:0] sxf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // The first entry of the window is the time origin.
  always_ff @(posedge clk_i) begin
    if (valid_i && first_i) begin
      t0_q <= time_i;
    end
    x1_q  <= (first_i) ? 32'd0 : time_i - t0_q;
    f1_q  <= angle_i;
    pxx_q <= x1_q * x1_q;
    pxf_q <= $signed({1'b0, x1_q}) * f1_q;
    x2_q  <= x1_q;
    f2_q  <= f1_q;
    if (clear_i) begin
      sx_q  <= '0;
      sxx_q <= '0;
      sf_q  <= '0;
      sxf_q <= '0;
    end else if (v2_q) begin
      sx_q  <= sx_q + (32+CW)'(x2_q);
      sxx_q <= sxx_q + (64+CW)'(pxx_q);
      sf_q  <= sf_q + (16+CW)'(f2_q);
      sxf_q <= sxf_q + (48+CW)'(pxf_q);
    end
  end

  assign busy_o = v1_q | v2_q;
  assign sx_o   = sx_q;
  assign sxx_o  = sxx_q;
  assign sf_o   = sf_q;
  assign sxf_o  = sxf_q;

endmodule

[rtl/wrf_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle, stops early once the remaining multiplier bits are zero.
module wrf_mul #(
  parameter int W = 39
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] p_o
);

  logic           busy_q, done_q;
  logic [2*W-1:0] p_q, m_q;
  logic [W-1:0]   b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= '0;
      m_q <= (2*W)'(a_i);
      b_q <= b_i;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        p_q <= p_q + m_q;
      end
      m_q <= m_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

[rtl/wrf_div.sv]
// Restoring divider, one quotient bit per cycle.
module wrf_div #(
  parameter int NW = 79,
  parameter int DW = 79
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int KW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [KW-1:0] cnt_q;
  logic [NW-1:0] dvd_q;
  logic [DW-1:0] dsr_q;
  logic [DW:0]   rem_q;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q[DW-1:0], dvd_q[NW-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= KW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == KW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? shifted - {1'b0, dsr_q} : shifted;
      dvd_q <= {dvd_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
